@@ rtl/color_markup_to_ansi_sgr_macros.svh @@
// ============================================================================
// Assertion macros for the colour markup translator
// Concurrent checks that compile away when SYNTHESIS is defined.
// ============================================================================
`ifndef COLOR_MARKUP_TO_ANSI_SGR_MACROS_SVH
`define COLOR_MARKUP_TO_ANSI_SGR_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define CMU_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("cmu check failed");
// next-cycle implication
`define CMU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("cmu check failed");
`else
`define CMU_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define CMU_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ rtl/cmu_pkg.sv @@
// ============================================================================
// cmu_pkg
// Shared types, character codes and lookup tables for the markup translator.
// ============================================================================
`default_nettype none

package cmu_pkg;

    // character codes
    localparam logic [7:0] CH_ESC  = 8'h1B;
    localparam logic [7:0] CH_AT   = 8'h40;
    localparam logic [7:0] CH_LSQ  = 8'h5B;
    localparam logic [7:0] CH_X    = 8'h78;
    localparam logic [7:0] CH_M    = 8'h6D;
    localparam logic [7:0] CH_D0   = 8'h30;
    localparam logic [7:0] CH_D9   = 8'h39;

    localparam logic [3:0] NUM_RANDOM = 4'd14;
    localparam logic [4:0] COLOR_SAT  = 5'd16;
    localparam logic [4:0] BODY_NONE  = 5'd0;

    // scan phase of the front end
    typedef enum logic [1:0] {
        PH_TEXT,
        PH_AT,
        PH_DIG_XLATE,
        PH_DIG_STRIP
    } t_scan_phase;

    typedef enum logic {
        JOB_BYTE,
        JOB_SGR
    } t_job_kind;

    // one queued job: a literal byte or an escape with a body
    typedef struct packed {
        t_job_kind   kind;
        logic [7:0]  byte_val;
        logic [4:0]  body_id;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_job_chan;

    // escape body: up to four characters, left aligned
    typedef struct packed {
        logic [2:0]  len;
        logic [31:0] chars;
    } t_body;

    // '@x' letter set, pick taken modulo 14
    function automatic logic [7:0] random_letter(input logic [3:0] pick);
        logic [3:0] idx;
        idx = (pick >= NUM_RANDOM) ? (pick - NUM_RANDOM) : pick;
        case (idx)
            4'd0:    random_letter = "b";
            4'd1:    random_letter = "g";
            4'd2:    random_letter = "c";
            4'd3:    random_letter = "r";
            4'd4:    random_letter = "m";
            4'd5:    random_letter = "y";
            4'd6:    random_letter = "w";
            4'd7:    random_letter = "B";
            4'd8:    random_letter = "G";
            4'd9:    random_letter = "C";
            4'd10:   random_letter = "R";
            4'd11:   random_letter = "M";
            4'd12:   random_letter = "W";
            default: random_letter = "Y";
        endcase
    endfunction

    // code letter to body id, BODY_NONE when unknown
    function automatic logic [4:0] letter_body(input logic [7:0] c);
        case (c)
            "n":     letter_body = 5'd1;
            "d":     letter_body = 5'd2;
            "b":     letter_body = 5'd3;
            "g":     letter_body = 5'd4;
            "c":     letter_body = 5'd5;
            "r":     letter_body = 5'd6;
            "m":     letter_body = 5'd7;
            "y":     letter_body = 5'd8;
            "w":     letter_body = 5'd9;
            "D":     letter_body = 5'd10;
            "B":     letter_body = 5'd11;
            "G":     letter_body = 5'd12;
            "C":     letter_body = 5'd13;
            "R":     letter_body = 5'd14;
            "M":     letter_body = 5'd15;
            "Y":     letter_body = 5'd16;
            "W":     letter_body = 5'd17;
            "0":     letter_body = 5'd18;
            "1":     letter_body = 5'd19;
            "2":     letter_body = 5'd20;
            "3":     letter_body = 5'd21;
            "4":     letter_body = 5'd22;
            "5":     letter_body = 5'd23;
            "6":     letter_body = 5'd24;
            "7":     letter_body = 5'd25;
            "l":     letter_body = 5'd26;
            "u":     letter_body = 5'd27;
            "o":     letter_body = 5'd28;
            "e":     letter_body = 5'd29;
            default: letter_body = BODY_NONE;
        endcase
    endfunction

    // fixed '@[n' colours mapped onto the shared body table
    function automatic logic [4:0] fixed_body(input logic [4:0] num);
        case (num)
            5'd1, 5'd11, 5'd14: fixed_body = 5'd5;
            5'd2, 5'd5, 5'd12:  fixed_body = 5'd4;
            5'd3, 5'd6, 5'd10:  fixed_body = 5'd8;
            5'd4, 5'd13:        fixed_body = 5'd6;
            5'd7, 5'd8, 5'd9:   fixed_body = 5'd16;
            5'd15:              fixed_body = 5'd9;
            default:            fixed_body = 5'd1;
        endcase
    endfunction

    function automatic t_body body_lookup(input logic [4:0] id);
        case (id)
            5'd2:    body_lookup = '{3'd4, "0;30"};
            5'd3:    body_lookup = '{3'd4, "0;34"};
            5'd4:    body_lookup = '{3'd4, "0;32"};
            5'd5:    body_lookup = '{3'd4, "0;36"};
            5'd6:    body_lookup = '{3'd4, "0;31"};
            5'd7:    body_lookup = '{3'd4, "0;35"};
            5'd8:    body_lookup = '{3'd4, "0;33"};
            5'd9:    body_lookup = '{3'd4, "0;37"};
            5'd10:   body_lookup = '{3'd4, "1;30"};
            5'd11:   body_lookup = '{3'd4, "1;34"};
            5'd12:   body_lookup = '{3'd4, "1;32"};
            5'd13:   body_lookup = '{3'd4, "1;36"};
            5'd14:   body_lookup = '{3'd4, "1;31"};
            5'd15:   body_lookup = '{3'd4, "1;35"};
            5'd16:   body_lookup = '{3'd4, "1;33"};
            5'd17:   body_lookup = '{3'd4, "1;37"};
            5'd18:   body_lookup = '{3'd2, {"40", 16'h0000}};
            5'd19:   body_lookup = '{3'd2, {"44", 16'h0000}};
            5'd20:   body_lookup = '{3'd2, {"42", 16'h0000}};
            5'd21:   body_lookup = '{3'd2, {"46", 16'h0000}};
            5'd22:   body_lookup = '{3'd2, {"41", 16'h0000}};
            5'd23:   body_lookup = '{3'd2, {"45", 16'h0000}};
            5'd24:   body_lookup = '{3'd2, {"43", 16'h0000}};
            5'd25:   body_lookup = '{3'd2, {"47", 16'h0000}};
            5'd26:   body_lookup = '{3'd1, {"5", 24'h000000}};
            5'd27:   body_lookup = '{3'd1, {"4", 24'h000000}};
            5'd28:   body_lookup = '{3'd1, {"1", 24'h000000}};
            5'd29:   body_lookup = '{3'd1, {"7", 24'h000000}};
            default: body_lookup = '{3'd1, {"0", 24'h000000}};
        endcase
    endfunction

endpackage

`default_nettype wire

@@ rtl/cmu_front.sv @@
// ============================================================================
// cmu_front
// Scans input text, tracks the '@' code state and posts one job per byte
// that produces output.
// ============================================================================
`default_nettype none
`include "color_markup_to_ansi_sgr_macros.svh"

module cmu_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_wdata,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [7:0]        i_text_byte,
    input  wire logic              i_text_end,
    input  wire logic [3:0]        i_random_pick,
    input  wire logic              i_q_full,
    output cmu_pkg::t_job_chan     o_push
);
    import cmu_pkg::*;

    t_scan_phase r_phase, n_phase;
    logic [4:0]  r_color, n_color;
    logic        r_parse_en;

    logic        accept;
    logic [7:0]  code_c;
    logic        is_digit;
    logic [7:0]  acc_val;
    logic [4:0]  acc_sat;
    logic [4:0]  lb;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    // parse enable register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parse_en <= 1'b1;
        end else if (i_cfg_we) begin
            r_parse_en <= i_cfg_wdata;
        end
    end

    // scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TEXT;
            r_color <= 5'd0;
        end else begin
            r_phase <= n_phase;
            r_color <= n_color;
        end
    end

    // code letter after '@', with '@x' replaced by the random pick
    assign code_c   = (i_text_byte == CH_X) ? random_letter(i_random_pick) : i_text_byte;
    assign lb       = letter_body(code_c);
    assign is_digit = (i_text_byte >= CH_D0) && (i_text_byte <= CH_D9);
    // colour accumulator: r_color * 10 + digit, at most 169
    assign acc_val  = ({3'b000, r_color} * 8'd10) + {4'h0, i_text_byte[3:0]};
    assign acc_sat  = (acc_val >= {3'b000, COLOR_SAT}) ? COLOR_SAT : acc_val[4:0];

    // next state and job classification
    always_comb begin
        n_phase              = r_phase;
        n_color              = r_color;
        o_push.valid         = 1'b0;
        o_push.job.kind      = JOB_BYTE;
        o_push.job.byte_val  = i_text_byte;
        o_push.job.body_id   = BODY_NONE;
        if (accept) begin
            unique case (r_phase)
                PH_TEXT: begin
                    if (i_text_byte != CH_AT || i_text_end) begin
                        o_push.valid = 1'b1;
                    end else begin
                        n_phase = PH_AT;
                    end
                end
                PH_AT: begin
                    n_phase = PH_TEXT;
                    if (code_c == CH_LSQ) begin
                        if (!i_text_end) begin
                            n_phase = r_parse_en ? PH_DIG_XLATE : PH_DIG_STRIP;
                            n_color = 5'd0;
                        end
                    end else if (code_c == CH_AT) begin
                        o_push.valid = 1'b1;
                    end else if (r_parse_en && lb != BODY_NONE) begin
                        o_push.valid       = 1'b1;
                        o_push.job.kind    = JOB_SGR;
                        o_push.job.body_id = lb;
                    end
                end
                PH_DIG_XLATE, PH_DIG_STRIP: begin
                    if (is_digit) begin
                        n_color = acc_sat;
                        if (i_text_end) begin
                            o_push.valid = (r_phase == PH_DIG_XLATE);
                            n_phase      = PH_TEXT;
                        end
                    end else begin
                        o_push.valid = (r_phase == PH_DIG_XLATE);
                        n_phase      = PH_TEXT;
                    end
                    o_push.job.kind    = JOB_SGR;
                    o_push.job.body_id = fixed_body(is_digit ? acc_sat : r_color);
                end
                default: begin
                    n_phase = PH_TEXT;
                end
            endcase
            if (i_text_end) begin
                n_phase = PH_TEXT;
            end
            if (n_phase == PH_TEXT) begin
                n_color = 5'd0;
            end
        end
    end

    // checks
    `CMU_ASSERT_NOW(a_color_sat, i_clk, i_rst_n, 1'b1, r_color <= COLOR_SAT)
    `CMU_ASSERT_NOW(a_text_clear, i_clk, i_rst_n, r_phase == PH_TEXT, r_color == 5'd0)

endmodule

`default_nettype wire

@@ rtl/cmu_queue.sv @@
// ============================================================================
// cmu_queue
// Small job queue between the scanner and the escape expander.
// ============================================================================
`default_nettype none
`include "color_markup_to_ansi_sgr_macros.svh"

module cmu_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  cmu_pkg::t_job_chan     i_push,
    output logic                   o_full,
    output cmu_pkg::t_job_chan     o_head,
    input  wire logic              i_pop
);
    import cmu_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full     = (r_cnt == CW'(DEPTH));
    assign do_push    = i_push.valid && !o_full;
    assign do_pop     = i_pop && (r_cnt != '0);
    assign o_head.valid = (r_cnt != '0);
    assign o_head.job   = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push.job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            r_cnt <= r_cnt + CW'(do_push) - CW'(do_pop);
        end
    end

    // checks
    `CMU_ASSERT_NOW(a_no_push_full, i_clk, i_rst_n, i_push.valid, !o_full)
    `CMU_ASSERT_NOW(a_no_pop_empty, i_clk, i_rst_n, i_pop, o_head.valid)

endmodule

`default_nettype wire

@@ rtl/cmu_back.sv @@
// ============================================================================
// cmu_back
// Expands queued jobs into output bytes, one byte per cycle while the
// output is not stalled, into a registered output stage.
// ============================================================================
`default_nettype none
`include "color_markup_to_ansi_sgr_macros.svh"

module cmu_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  cmu_pkg::t_job_chan     i_head,
    output logic                   o_pop,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [7:0]             o_out_byte,
    output logic                   o_run_last
);
    import cmu_pkg::*;

    logic [2:0] r_pos;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;

    t_body      body;
    logic [2:0] seq_len;
    logic [2:0] bpos;
    logic [7:0] cur_byte;
    logic       cur_last;
    logic       load;

    assign body    = body_lookup(i_head.job.body_id);
    assign seq_len = body.len + 3'd3;
    assign bpos    = r_pos - 3'd2;

    // byte at the current position of the job
    always_comb begin
        cur_byte = i_head.job.byte_val;
        cur_last = 1'b1;
        if (i_head.job.kind == JOB_SGR) begin
            cur_last = (r_pos == seq_len - 3'd1);
            if (r_pos == 3'd0) begin
                cur_byte = CH_ESC;
            end else if (r_pos == 3'd1) begin
                cur_byte = CH_LSQ;
            end else if (cur_last) begin
                cur_byte = CH_M;
            end else begin
                case (bpos[1:0])
                    2'd0:    cur_byte = body.chars[31:24];
                    2'd1:    cur_byte = body.chars[23:16];
                    2'd2:    cur_byte = body.chars[15:8];
                    default: cur_byte = body.chars[7:0];
                endcase
            end
        end
    end

    assign load  = i_head.valid && (!r_valid || i_ready);
    assign o_pop = load && cur_last;

    // position within the current escape
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= 3'd0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_pos <= cur_last ? 3'd0 : r_pos + 3'd1;
            end
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= cur_byte;
            r_last <= cur_last;
        end
    end

    assign o_valid    = r_valid;
    assign o_out_byte = r_byte;
    assign o_run_last = r_last;

    // checks
    `CMU_ASSERT_NOW(a_pos_in_sgr, i_clk, i_rst_n, r_pos != 3'd0,
                    i_head.valid && i_head.job.kind == JOB_SGR)
    `CMU_ASSERT_NEXT(a_pop_restarts, i_clk, i_rst_n, o_pop, r_pos == 3'd0)

endmodule

`default_nettype wire

@@ rtl/color_markup_to_ansi_sgr.sv @@
// ============================================================================
// color_markup_to_ansi_sgr
// Colour markup to ANSI SGR translator: scanner, job queue, escape expander.
// ============================================================================
//  channel   direction  signals
//  ------------------------------------------------------------------------
//  text in   input      i_valid/o_ready, i_text_byte, i_text_end, i_random_pick
//  bytes out output     o_valid/i_ready, o_out_byte, o_run_last
//  config    input      i_cfg_we, i_cfg_wdata (parse enable, no wait)
//
//  Plain bytes pass one per cycle while the output is not stalled.
//  An escape leaves as 4 to 7 bytes, one per cycle unless stalled.
//  The scanner keeps taking text until QUEUE_DEPTH jobs are waiting.
//  Reset is synchronous and active low; parse enable resets to 1.
//  A stall on the output fills the queue, then drops o_ready.
// ============================================================================
`default_nettype none

module color_markup_to_ansi_sgr #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_wdata,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_text_byte,
    input  wire logic       i_text_end,
    input  wire logic [3:0] i_random_pick,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_run_last
);
    import cmu_pkg::*;

    t_job_chan push;
    t_job_chan head;
    logic      q_full;
    logic      pop;

    // scanner
    cmu_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_text_byte   (i_text_byte),
        .i_text_end    (i_text_end),
        .i_random_pick (i_random_pick),
        .i_q_full      (q_full),
        .o_push        (push)
    );

    // job queue
    cmu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (q_full),
        .o_head  (head),
        .i_pop   (pop)
    );

    // expander
    cmu_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_byte (o_out_byte),
        .o_run_last (o_run_last)
    );

endmodule

`default_nettype wire
